FILE: design/triangle_normal_and_bounds_assert.svh
// assertion macros used by the checker file
`ifndef TRIANGLE_NORMAL_AND_BOUNDS_ASSERT_SVH
`define TRIANGLE_NORMAL_AND_BOUNDS_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TNB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tnb assertion failed");

// next-cycle implication, disabled while in reset
`define TNB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tnb assertion failed");

// plain check that also holds during reset
`define TNB_ASSERT_ALWAYS(lbl, clk, cond) \
  lbl: assert property (@(posedge clk) (cond)) \
    else $error("tnb assertion failed");

`endif

FILE: design/tnb_pkg.sv
// shared widths, register codes and types for the triangle normal block
package tnb_pkg;

  localparam int POS_W  = 32;
  localparam int NORM_W = 16;
  localparam int CT_W   = 16;
  localparam int NT_W   = NORM_W - 1;
  localparam int RAD_W  = POS_W - 1;
  localparam int E_W    = POS_W + 1;
  localparam int LO_W   = 32;
  localparam int MUL_W  = (E_W > LO_W + 1) ? E_W : LO_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int C_W    = 2 * E_W + 2;
  localparam int M_W    = 30;
  localparam int SQ_W   = 2 * M_W + 2;
  localparam int BIT_W  = SQ_W - 1;
  localparam int LEN_W  = M_W + 1;
  localparam int QW     = NORM_W;
  localparam int DIV_W  = LEN_W + QW;
  localparam int ACC_W  = 2 * LO_W + 2;
  localparam int TSQ_W  = 2 * CT_W;
  localparam int CNT_W  = ($clog2(QW) > 4) ? $clog2(QW) : 4;

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_CT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_NT = 1'b1;

  localparam logic [CT_W-1:0] CT_RESET = CT_W'(7);
  localparam logic [NT_W-1:0] NT_RESET = NT_W'(2);

  localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1) << (NORM_W - 2);
  localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    logic                    clear;
    logic                    update;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
  } bnd_ctrl_t;

endpackage

FILE: design/tnb_vtx_if.sv
// input vertex channel
interface tnb_vtx_if;
  import tnb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     start_new;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;
  logic                     normal_given;

  modport source (output valid, start_new, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  normal_given, input ready);
  modport sink (input valid, start_new, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                normal_given, output ready);
endinterface

FILE: design/tnb_res_if.sv
// output vertex channel
interface tnb_res_if;
  import tnb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  out_x;
  logic signed [POS_W-1:0]  out_y;
  logic signed [POS_W-1:0]  out_z;
  logic signed [NORM_W-1:0] out_nx;
  logic signed [NORM_W-1:0] out_ny;
  logic signed [NORM_W-1:0] out_nz;
  logic                     normal_repaired;
  logic                     last_of_triangle;
  logic [RAD_W-1:0]         bound_radius;

  modport source (output valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
                  normal_repaired, last_of_triangle, bound_radius, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
                normal_repaired, last_of_triangle, bound_radius, output ready);
endinterface

FILE: design/tnb_mul.sv
// shared signed multiplier with registered product
module tnb_mul (
  input  logic                               clk_i,
  input  logic signed [tnb_pkg::MUL_W-1:0]   a_i,
  input  logic signed [tnb_pkg::MUL_W-1:0]   b_i,
  output logic signed [tnb_pkg::PROD_W-1:0]  prod_o
);
  import tnb_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // one product per cycle, available the cycle after issue
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;
endmodule

FILE: design/tnb_bounds.sv
// running bounding box and half-largest-extent radius
module tnb_bounds (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tnb_pkg::bnd_ctrl_t          ctrl_i,
  output logic [tnb_pkg::RAD_W-1:0]   radius_o
);
  import tnb_pkg::*;

  logic signed [POS_W-1:0] min_q [3];
  logic signed [POS_W-1:0] max_q [3];
  logic signed [POS_W-1:0] pos   [3];
  logic [E_W-1:0]          ext   [3];
  logic [E_W-1:0]          ext_max;
  logic [POS_W-1:0]        half;

  assign pos[0] = ctrl_i.px;
  assign pos[1] = ctrl_i.py;
  assign pos[2] = ctrl_i.pz;

  // box update, clear on new mesh
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        min_q[i] <= POS_MAX;
        max_q[i] <= POS_MIN;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < 3; i++) begin
        min_q[i] <= POS_MAX;
        max_q[i] <= POS_MIN;
      end
    end else if (ctrl_i.update) begin
      for (int i = 0; i < 3; i++) begin
        if (pos[i] < min_q[i]) min_q[i] <= pos[i];
        if (pos[i] > max_q[i]) max_q[i] <= pos[i];
      end
    end
  end

  // largest extent, halved and saturated
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = E_W'(max_q[i]) - E_W'(min_q[i]);
    end
    ext_max = ext[0];
    if (ext[1] > ext_max) ext_max = ext[1];
    if (ext[2] > ext_max) ext_max = ext[2];
    half = ext_max[E_W-1:1];
    radius_o = half[POS_W-1] ? {RAD_W{1'b1}} : half[RAD_W-1:0];
  end
endmodule

FILE: design/triangle_normal_and_bounds.sv
// Triangle face normal and bounding box. Vertices come in threes; the first and second of a
// triangle are registered and held. The third keeps the input stalled while a sequencer
// runs one shared 33x33 multiplier (cross product, squares), a one-bit-per-cycle
// normalising shift, a bit-serial square root and a restoring divider per component,
// then checks the supplied normals and emits the three vertices. A degenerate face skips
// the shift, root and divider. The input is ready again once the third vertex is loaded
// into the result register, which waits while the result side stalls. Registers sit at byte
// addresses 0 (cross length threshold) and 4 (normal length threshold).
module triangle_normal_and_bounds (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tnb_vtx_if.sink                        vin_i,
  tnb_res_if.source                      vout_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tnb_pkg::ADDR_W-1:0]     paddr,
  input  logic [tnb_pkg::DATA_W-1:0]     pwdata,
  output logic [tnb_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import tnb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EDGE  = 4'd1;
  localparam logic [3:0] S_CROSS = 4'd2;
  localparam logic [3:0] S_MAG   = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_LSQ   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DIVI  = 4'd8;
  localparam logic [3:0] S_DIVS  = 4'd9;
  localparam logic [3:0] S_KEEP  = 4'd10;
  localparam logic [3:0] S_BUPD  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]               state_q;
  logic [1:0]               phase_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [1:0]               idx_q;
  logic [CT_W-1:0]          ct_q;
  logic [NT_W-1:0]          nt_q;

  logic signed [POS_W-1:0]  pos_q  [3][3];
  logic signed [NORM_W-1:0] nrm_q  [3][3];
  logic                     given_q [3];
  logic signed [E_W-1:0]    e1_q [3];
  logic signed [E_W-1:0]    e2_q [3];
  logic signed [C_W-1:0]    c_q  [3];
  logic [C_W-1:0]           mag_q [3];
  logic                     neg_q [3];
  logic [ACC_W-1:0]         acc_q;
  logic [TSQ_W-1:0]         thrsq_q;
  logic [SQ_W-1:0]          x_q;
  logic [SQ_W-1:0]          res_q;
  logic [BIT_W-1:0]         bit_q;
  logic [LEN_W-1:0]         len_q;
  logic [DIV_W-1:0]         r_q;
  logic [DIV_W-1:0]         dsh_q;
  logic [QW-1:0]            q_q;
  logic signed [NORM_W-1:0] face_q [3];
  logic                     keep_q [3];

  logic                     ov_q;
  logic signed [POS_W-1:0]  ox_q, oy_q, oz_q;
  logic signed [NORM_W-1:0] onx_q, ony_q, onz_q;
  logic                     orep_q, olast_q;
  logic [RAD_W-1:0]         orad_q;

  logic                     in_xfer;
  logic [1:0]               slot;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [C_W-1:0]           orv;
  logic                     big, allzero;
  logic [ACC_W-1:0]         sq_sum;
  logic [ACC_W-1:0]         nsq_sum;
  logic [SQ_W-1:0]          sqrt_tst;
  logic                     div_ge;
  logic [QW-1:0]            q_next;
  logic                     out_free;
  bnd_ctrl_t                bctrl;
  logic [RAD_W-1:0]         radius;

  // handshake and apb
  assign vin_i.ready = (state_q == S_IDLE);
  assign in_xfer     = vin_i.valid && vin_i.ready;
  assign slot        = vin_i.start_new ? 2'd0 : phase_q;
  assign out_free    = !ov_q || vout_o.ready;
  assign pready      = 1'b1;

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_CT:  prdata = DATA_W'(ct_q);
      REG_NT:  prdata = DATA_W'(nt_q);
      default: prdata = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ct_q <= CT_RESET;
      nt_q <= NT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[ADDR_W-1:2])
        REG_CT:  ct_q <= pwdata[CT_W-1:0];
        REG_NT:  nt_q <= pwdata[NT_W-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_CROSS: begin
        case (cnt_q)
          CNT_W'(0): begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
          CNT_W'(1): begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
          CNT_W'(2): begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
          CNT_W'(3): begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
          CNT_W'(4): begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
          CNT_W'(5): begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
          default: ;
        endcase
      end
      S_SQ: begin
        case (cnt_q)
          CNT_W'(0): mul_a = MUL_W'(ct_q);
          CNT_W'(1): mul_a = MUL_W'(mag_q[0][LO_W-1:0]);
          CNT_W'(2): mul_a = MUL_W'(mag_q[1][LO_W-1:0]);
          CNT_W'(3): mul_a = MUL_W'(mag_q[2][LO_W-1:0]);
          default: ;
        endcase
        mul_b = mul_a;
      end
      S_LSQ: begin
        case (cnt_q)
          CNT_W'(0): mul_a = MUL_W'(mag_q[0][M_W-1:0]);
          CNT_W'(1): mul_a = MUL_W'(mag_q[1][M_W-1:0]);
          CNT_W'(2): mul_a = MUL_W'(mag_q[2][M_W-1:0]);
          default: ;
        endcase
        mul_b = mul_a;
      end
      S_KEEP: begin
        case (cnt_q)
          CNT_W'(0): mul_a = MUL_W'(nt_q);
          CNT_W'(1): mul_a = MUL_W'(nrm_q[0][0]);
          CNT_W'(2): mul_a = MUL_W'(nrm_q[0][1]);
          CNT_W'(3): mul_a = MUL_W'(nrm_q[0][2]);
          CNT_W'(4): mul_a = MUL_W'(nrm_q[1][0]);
          CNT_W'(5): mul_a = MUL_W'(nrm_q[1][1]);
          CNT_W'(6): mul_a = MUL_W'(nrm_q[1][2]);
          CNT_W'(7): mul_a = MUL_W'(nrm_q[2][0]);
          CNT_W'(8): mul_a = MUL_W'(nrm_q[2][1]);
          CNT_W'(9): mul_a = MUL_W'(nrm_q[2][2]);
          default: ;
        endcase
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  tnb_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // helper terms for the sequencer
  always_comb begin
    orv      = mag_q[0] | mag_q[1] | mag_q[2];
    allzero  = ~|orv;
    big      = |orv[C_W-1:LO_W];
    sq_sum   = acc_q + ACC_W'(prod[2*LO_W-1:0]);
    nsq_sum  = acc_q + ACC_W'(prod[2*NORM_W-1:0]);
    sqrt_tst = res_q + SQ_W'(bit_q);
    div_ge   = (r_q >= dsh_q);
    q_next   = {q_q[QW-2:0], div_ge};
  end

  // bounding box control
  always_comb begin
    bctrl.clear  = in_xfer && vin_i.start_new;
    bctrl.update = (state_q == S_BUPD);
    bctrl.px     = pos_q[idx_q][0];
    bctrl.py     = pos_q[idx_q][1];
    bctrl.pz     = pos_q[idx_q][2];
  end

  tnb_bounds u_bounds (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (bctrl),
    .radius_o (radius)
  );

  // sequencer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 2'd0;
      cnt_q   <= '0;
      idx_q   <= 2'd0;
      ov_q    <= 1'b0;
      for (int i = 0; i < 3; i++) given_q[i] <= 1'b0;
    end else begin
      // result taken and no new one loaded in the same cycle
      if (ov_q && vout_o.ready && !(state_q == S_OUT && out_free)) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            given_q[slot] <= vin_i.normal_given;
            if (slot == 2'd2) begin
              phase_q <= 2'd0;
              state_q <= S_EDGE;
            end else begin
              phase_q <= slot + 2'd1;
            end
          end
        end
        S_EDGE: begin
          cnt_q   <= '0;
          state_q <= S_CROSS;
        end
        S_CROSS: begin
          if (cnt_q == CNT_W'(6)) begin
            state_q <= S_MAG;
          end
          cnt_q <= (cnt_q == CNT_W'(6)) ? '0 : cnt_q + CNT_W'(1);
        end
        S_MAG: begin
          cnt_q   <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (cnt_q == CNT_W'(4)) begin
            cnt_q <= '0;
            if (allzero || (!big && sq_sum < ACC_W'({thrsq_q, {LO_W{1'b0}}}))) begin
              state_q <= S_KEEP;
            end else begin
              state_q <= S_NORM;
            end
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_NORM: begin
          if (!(|orv[C_W-1:M_W]) && orv[M_W-1]) begin
            cnt_q   <= '0;
            state_q <= S_LSQ;
          end
        end
        S_LSQ: begin
          if (cnt_q == CNT_W'(3)) begin
            cnt_q   <= '0;
            state_q <= S_SQRT;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_SQRT: begin
          if (bit_q[0]) begin
            idx_q   <= 2'd0;
            state_q <= S_DIVI;
          end
        end
        S_DIVI: begin
          cnt_q   <= '0;
          state_q <= S_DIVS;
        end
        S_DIVS: begin
          if (cnt_q == CNT_W'(QW-1)) begin
            cnt_q <= '0;
            if (idx_q == 2'd2) begin
              state_q <= S_KEEP;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= S_DIVI;
            end
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_KEEP: begin
          if (cnt_q == CNT_W'(10)) begin
            cnt_q   <= '0;
            idx_q   <= 2'd0;
            state_q <= S_BUPD;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_BUPD: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            ov_q <= 1'b1;
            if (idx_q == 2'd2) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= S_BUPD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          pos_q[slot][0] <= vin_i.pos_x;
          pos_q[slot][1] <= vin_i.pos_y;
          pos_q[slot][2] <= vin_i.pos_z;
          nrm_q[slot][0] <= vin_i.norm_x;
          nrm_q[slot][1] <= vin_i.norm_y;
          nrm_q[slot][2] <= vin_i.norm_z;
        end
      end
      // edges from the first vertex
      S_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= E_W'(pos_q[1][i]) - E_W'(pos_q[0][i]);
          e2_q[i] <= E_W'(pos_q[2][i]) - E_W'(pos_q[0][i]);
          c_q[i]  <= '0;
        end
      end
      // cross product accumulation, one product behind issue
      S_CROSS: begin
        case (cnt_q)
          CNT_W'(1): c_q[0] <= c_q[0] + C_W'(prod);
          CNT_W'(2): c_q[0] <= c_q[0] - C_W'(prod);
          CNT_W'(3): c_q[1] <= c_q[1] + C_W'(prod);
          CNT_W'(4): c_q[1] <= c_q[1] - C_W'(prod);
          CNT_W'(5): c_q[2] <= c_q[2] + C_W'(prod);
          CNT_W'(6): c_q[2] <= c_q[2] - C_W'(prod);
          default: ;
        endcase
      end
      S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= c_q[i][C_W-1];
          mag_q[i] <= c_q[i][C_W-1] ? C_W'(-c_q[i]) : c_q[i];
        end
        acc_q <= '0;
      end
      // degenerate test on the exact squared length
      S_SQ: begin
        case (cnt_q)
          CNT_W'(1): thrsq_q <= prod[TSQ_W-1:0];
          CNT_W'(2), CNT_W'(3): acc_q <= sq_sum;
          CNT_W'(4): begin
            acc_q     <= '0;
            face_q[0] <= '0;
            face_q[1] <= NORM_ONE;
            face_q[2] <= '0;
          end
          default: ;
        endcase
      end
      // bring the top bit of the largest component to its place
      S_NORM: begin
        if (|orv[C_W-1:M_W]) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (!orv[M_W-1]) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end
        acc_q <= '0;
      end
      S_LSQ: begin
        if (cnt_q == CNT_W'(3)) begin
          x_q   <= SQ_W'(acc_q + ACC_W'(prod[2*M_W-1:0]));
          res_q <= '0;
          bit_q <= {1'b1, {(BIT_W-1){1'b0}}};
        end else if (cnt_q != CNT_W'(0)) begin
          acc_q <= acc_q + ACC_W'(prod[2*M_W-1:0]);
        end
      end
      // bit-serial integer square root
      S_SQRT: begin
        if (x_q >= sqrt_tst) begin
          x_q   <= x_q - sqrt_tst;
          res_q <= (res_q >> 1) + SQ_W'(bit_q);
          if (bit_q[0]) len_q <= LEN_W'((res_q >> 1) + SQ_W'(bit_q));
        end else begin
          res_q <= res_q >> 1;
          if (bit_q[0]) len_q <= LEN_W'(res_q >> 1);
        end
        bit_q <= bit_q >> 2;
      end
      // rounded quotient of one component by the length
      S_DIVI: begin
        r_q   <= DIV_W'({mag_q[idx_q][M_W-1:0], {(QW-1){1'b0}}}) + DIV_W'(len_q);
        dsh_q <= DIV_W'({len_q, 1'b0}) << (QW - 1);
        q_q   <= '0;
      end
      S_DIVS: begin
        if (div_ge) r_q <= r_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        q_q   <= q_next;
        if (cnt_q == CNT_W'(QW-1)) begin
          face_q[idx_q] <= neg_q[idx_q] ? NORM_W'(-q_next) : NORM_W'(q_next);
        end
      end
      // supplied normal length check per vertex
      S_KEEP: begin
        case (cnt_q)
          CNT_W'(0): acc_q <= '0;
          CNT_W'(1): thrsq_q <= prod[TSQ_W-1:0];
          CNT_W'(4): begin
            keep_q[0] <= given_q[0] && (nsq_sum > ACC_W'(thrsq_q));
            acc_q     <= '0;
          end
          CNT_W'(7): begin
            keep_q[1] <= given_q[1] && (nsq_sum > ACC_W'(thrsq_q));
            acc_q     <= '0;
          end
          CNT_W'(10): begin
            keep_q[2] <= given_q[2] && (nsq_sum > ACC_W'(thrsq_q));
            acc_q     <= '0;
          end
          default: acc_q <= nsq_sum;
        endcase
      end
      // result register load
      S_OUT: begin
        if (out_free) begin
          ox_q    <= pos_q[idx_q][0];
          oy_q    <= pos_q[idx_q][1];
          oz_q    <= pos_q[idx_q][2];
          onx_q   <= keep_q[idx_q] ? nrm_q[idx_q][0] : face_q[0];
          ony_q   <= keep_q[idx_q] ? nrm_q[idx_q][1] : face_q[1];
          onz_q   <= keep_q[idx_q] ? nrm_q[idx_q][2] : face_q[2];
          orep_q  <= given_q[idx_q] && !keep_q[idx_q];
          olast_q <= (idx_q == 2'd2);
          orad_q  <= radius;
        end
      end
      default: ;
    endcase
  end

  // result channel
  assign vout_o.valid            = ov_q;
  assign vout_o.out_x            = ox_q;
  assign vout_o.out_y            = oy_q;
  assign vout_o.out_z            = oz_q;
  assign vout_o.out_nx           = onx_q;
  assign vout_o.out_ny           = ony_q;
  assign vout_o.out_nz           = onz_q;
  assign vout_o.normal_repaired  = orep_q;
  assign vout_o.last_of_triangle = olast_q;
  assign vout_o.bound_radius     = orad_q;
endmodule

FILE: design/tnb_checker.sv
// port-level checks for the triangle normal block, bound to the top level
`include "triangle_normal_and_bounds_assert.svh"

module tnb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             out_last_i,
  input logic signed [tnb_pkg::POS_W-1:0] out_x_i,
  input logic signed [tnb_pkg::POS_W-1:0] out_y_i,
  input logic signed [tnb_pkg::POS_W-1:0] out_z_i,
  input logic signed [tnb_pkg::NORM_W-1:0] out_nx_i,
  input logic signed [tnb_pkg::NORM_W-1:0] out_ny_i,
  input logic signed [tnb_pkg::NORM_W-1:0] out_nz_i,
  input logic [tnb_pkg::RAD_W-1:0]        out_rad_i
);
  import tnb_pkg::*;

  // a stalled result stays offered
  `TNB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a stalled result keeps its payload
  `TNB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_x_i) && $stable(out_y_i) && $stable(out_z_i) && $stable(out_nx_i) && $stable(out_ny_i) && $stable(out_nz_i) && $stable(out_rad_i))

  // no new vertex while a triangle is still being emitted
  `TNB_ASSERT_NOW(a_busy_mid_tri, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i, !in_ready_i)

  // nothing offered while in reset
  `TNB_ASSERT_ALWAYS(a_reset_quiet, clk_i, rst_ni || !out_valid_i)
endmodule

bind triangle_normal_and_bounds tnb_checker u_tnb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (vin_i.ready),
  .out_valid_i (vout_o.valid),
  .out_ready_i (vout_o.ready),
  .out_last_i  (vout_o.last_of_triangle),
  .out_x_i     (vout_o.out_x),
  .out_y_i     (vout_o.out_y),
  .out_z_i     (vout_o.out_z),
  .out_nx_i    (vout_o.out_nx),
  .out_ny_i    (vout_o.out_ny),
  .out_nz_i    (vout_o.out_nz),
  .out_rad_i   (vout_o.bound_radius)
);
